### design/vfbv_pkg.sv
package vfbv_pkg;

    // Fixed field widths of the command, result and configuration ports
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 5;
    localparam int CRD_W   = 6;
    localparam int RAD_W   = 4;
    localparam int CNT_W   = 13;
    localparam int VOX_W   = 3;
    localparam int CFG_A_W = 2;
    localparam int OFF_W   = RAD_W + 1;

    localparam int GRID_DIM_DEF   = 32;
    localparam int MAX_RADIUS_DEF = 8;

    localparam logic [CRD_W-1:0] SIZE_RST   = 6'd32;
    localparam logic [RAD_W-1:0] RADIUS_RST = 4'd4;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_RADIUS = 2'd3;

    // Voxel values of interest
    localparam logic signed [VOX_W-1:0] VOX_ZERO    = 3'sd0;
    localparam logic signed [VOX_W-1:0] VOX_SURFACE = 3'sd1;
    localparam logic signed [VOX_W-1:0] VOX_INSIDE  = -3'sd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN1,
        ST_GAP1,
        ST_SCAN2,
        ST_GAP2,
        ST_FINAL,
        ST_QUERY,
        ST_LAST,
        ST_REPORT
    } state_t;

    // Operation carried by a read into the data stage
    typedef enum logic [1:0] {
        OP_P1,
        OP_P2,
        OP_FIN,
        OP_QRY
    } op_t;

endpackage

### design/voxel_fill_ball_volume_engine_core.sv
// Channel   Signals                                      Direction  Handshake
// command   start, kind, x_index, y_index, z_index       in         start & !busy
// result    done, done_kind, ball_count                  out        done, one cycle
// config    cfg_valid, cfg_index, cfg_data, cfg_ready    in         cfg_valid & cfg_ready
//
// Every command gives one result. All state lives in one voxel memory with a
// registered read; the sequencer reads, modifies and writes one cell a cycle.
// Clear writes all 2^(3*ceil(log2(GRID_DIM))) cells (32768 by default); mark writes at most one.
// Query visits (2R)^3 offsets, 512 at R = 4, reading only those in the ball and the grid.
// Fill: per axis, each line of n cells is walked once, and walked again up to its
// closing position if it holds a surface pair; then every cell in use is read once
// to finish it before the result is reported.
// After reset the same clearing pass as a clear command runs with busy high;
// configuration writes are taken at any time. The receiver cannot stall.
module voxel_fill_ball_volume_engine_core
    import vfbv_pkg::*;
#(
    parameter int GRID_DIM   = GRID_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [IDX_W-1:0]    x_index,
    input  logic [IDX_W-1:0]    y_index,
    input  logic [IDX_W-1:0]    z_index,
    output logic                done,
    output logic [KIND_W-1:0]   done_kind,
    output logic [CNT_W-1:0]    ball_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_A_W-1:0]  cfg_index,
    input  logic [CRD_W-1:0]    cfg_data
);

    localparam int AW     = $clog2(GRID_DIM);
    localparam int ADDR_W = 3 * AW;
    localparam int DEPTH  = 1 << ADDR_W;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CRD_W-1:0] cx,
        input logic [CRD_W-1:0] cy,
        input logic [CRD_W-1:0] cz
    );
        return {AW'(cx), AW'(cy), AW'(cz)};
    endfunction

    // Voxel memory
    logic signed [VOX_W-1:0] mem [DEPTH];
    logic signed [VOX_W-1:0] rd_data_reg;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VOX_W-1:0] wr_data;

    // Configuration
    logic [CRD_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [RAD_W-1:0] radius_reg;

    // Sequencer state
    state_t            state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]  xq_reg, xq_next, yq_reg, yq_next, zq_reg, zq_next;
    logic [1:0]        axis_reg, axis_next;
    logic [CRD_W-1:0]  t_reg, t_next, u_reg, u_next, v_reg, v_next;
    logic [CRD_W-1:0]  lim_reg, lim_next;
    logic              have_lim_reg, have_lim_next;
    logic              par_reg, par_next;
    logic signed [OFF_W-1:0] qa_reg, qa_next, qb_reg, qb_next, qc_reg, qc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              report_reg, report_next;

    // Data stage: what the read issued last cycle is for
    logic              pv_reg, pv_next;
    op_t               pop_reg, pop_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;
    logic [CRD_W-1:0]  pt_reg, pt_next;

    // Result
    logic              done_reg, done_next;
    logic [KIND_W-1:0] done_kind_reg, done_kind_next;
    logic [CNT_W-1:0]  ball_count_reg, ball_count_next;

    // Used sizes and radius
    logic [CRD_W-1:0] sx, sy, sz;
    logic [RAD_W-1:0] rad;
    assign sx  = (int'(size_x_reg) > GRID_DIM) ? CRD_W'(GRID_DIM) : size_x_reg;
    assign sy  = (int'(size_y_reg) > GRID_DIM) ? CRD_W'(GRID_DIM) : size_y_reg;
    assign sz  = (int'(size_z_reg) > GRID_DIM) ? CRD_W'(GRID_DIM) : size_z_reg;
    assign rad = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;

    // Line walker: map (axis, t, u, v) to a cell and the line bounds
    logic [CRD_W-1:0] cx, cy, cz, n_len, u_lim, v_lim;
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                cx = t_reg; cy = u_reg; cz = v_reg;
                n_len = sx; u_lim = sy; v_lim = sz;
            end
            2'd1:
            begin
                cx = u_reg; cy = t_reg; cz = v_reg;
                n_len = sy; u_lim = sx; v_lim = sz;
            end
            default:
            begin
                cx = u_reg; cy = v_reg; cz = t_reg;
                n_len = sz; u_lim = sx; v_lim = sy;
            end
        endcase
    end

    logic t_end, u_end, v_end;
    assign t_end = (t_reg == n_len - 6'd1);
    assign u_end = (u_reg == u_lim - 6'd1);
    assign v_end = (v_reg == v_lim - 6'd1);

    // Query geometry
    logic signed [OFF_W-1:0] neg_r, rm1;
    logic signed [10:0]      qa_w, qb_w, qc_w, sq_sum;
    logic [10:0]             rr;
    logic signed [CRD_W:0]   px, py, pz;
    logic                    q_in, q_last;
    assign neg_r  = -$signed({1'b0, rad});
    assign rm1    = $signed({1'b0, rad}) - 5'sd1;
    assign qa_w   = 11'(qa_reg);
    assign qb_w   = 11'(qb_reg);
    assign qc_w   = 11'(qc_reg);
    assign sq_sum = qa_w * qa_w + qb_w * qb_w + qc_w * qc_w;
    assign rr     = 11'(rad) * 11'(rad);
    assign px     = $signed({2'b00, xq_reg}) + 7'(qa_reg);
    assign py     = $signed({2'b00, yq_reg}) + 7'(qb_reg);
    assign pz     = $signed({2'b00, zq_reg}) + 7'(qc_reg);
    assign q_in   = (px >= 0) && (px < $signed({1'b0, sx}))
                 && (py >= 0) && (py < $signed({1'b0, sy}))
                 && (pz >= 0) && (pz < $signed({1'b0, sz}))
                 && ($unsigned(sq_sum) <= rr);
    assign q_last = (qa_reg == rm1) && (qb_reg == rm1) && (qc_reg == rm1);

    logic accept, mark_ok, close_evt;
    assign accept  = start && (state_reg == ST_IDLE);
    assign mark_ok = ({1'b0, x_index} < sx) && ({1'b0, y_index} < sy)
                  && ({1'b0, z_index} < sz);

    // Data stage and sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        xq_next         = xq_reg;
        yq_next         = yq_reg;
        zq_next         = zq_reg;
        axis_next       = axis_reg;
        t_next          = t_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        lim_next        = lim_reg;
        have_lim_next   = have_lim_reg;
        par_next        = par_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        qc_next         = qc_reg;
        cnt_next        = cnt_reg;
        sweep_next      = sweep_reg;
        report_next     = report_reg;
        pv_next         = 1'b0;
        pop_next        = pop_reg;
        paddr_next      = paddr_reg;
        pt_next         = pt_reg;
        done_next       = 1'b0;
        done_kind_next  = done_kind_reg;
        ball_count_next = ball_count_reg;
        rd_en           = 1'b0;
        rd_addr         = cell_addr(cx, cy, cz);
        wr_en           = 1'b0;
        wr_addr         = paddr_reg;
        wr_data         = VOX_ZERO;
        close_evt       = 1'b0;

        // Finish the read issued last cycle
        if (pv_reg)
        begin
            unique case (pop_reg)
                OP_P1:
                begin
                    if (rd_data_reg == VOX_SURFACE)
                    begin
                        if (par_reg)
                        begin
                            close_evt     = 1'b1;
                            lim_next      = pt_reg;
                            have_lim_next = 1'b1;
                        end
                        par_next = !par_reg;
                    end
                end
                OP_P2:
                begin
                    if (rd_data_reg == VOX_SURFACE)
                    begin
                        par_next = !par_reg;
                    end
                    else if (par_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg - 3'sd1;
                    end
                end
                OP_FIN:
                begin
                    if (rd_data_reg <= VOX_INSIDE)
                    begin
                        wr_en   = 1'b1;
                        wr_data = VOX_SURFACE;
                    end
                    else if (rd_data_reg != VOX_ZERO)
                    begin
                        wr_en   = 1'b1;
                        wr_data = VOX_ZERO;
                    end
                end
                OP_QRY:
                begin
                    if ((rd_data_reg != VOX_ZERO) && (cnt_reg != COUNT_MAX))
                    begin
                        cnt_next = cnt_reg + 13'd1;
                    end
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    xq_next   = x_index;
                    yq_next   = y_index;
                    zq_next   = z_index;
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            sweep_next  = '0;
                            report_next = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        KIND_MARK:
                        begin
                            wr_en   = mark_ok;
                            wr_addr = cell_addr({1'b0, x_index}, {1'b0, y_index},
                                                {1'b0, z_index});
                            wr_data = VOX_SURFACE;
                            state_next = ST_REPORT;
                        end
                        KIND_FILL:
                        begin
                            if ((sx == '0) || (sy == '0) || (sz == '0))
                            begin
                                state_next = ST_REPORT;
                            end
                            else
                            begin
                                axis_next     = 2'd0;
                                t_next        = '0;
                                u_next        = '0;
                                v_next        = '0;
                                par_next      = 1'b0;
                                have_lim_next = 1'b0;
                                state_next    = ST_SCAN1;
                            end
                        end
                        default:
                        begin
                            cnt_next = '0;
                            qa_next  = neg_r;
                            qb_next  = neg_r;
                            qc_next  = neg_r;
                            state_next = (rad == '0) ? ST_REPORT : ST_QUERY;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = VOX_ZERO;
                if (sweep_reg == '1)
                begin
                    state_next = report_reg ? ST_REPORT : ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_SCAN1:
            begin
                rd_en      = 1'b1;
                pv_next    = 1'b1;
                pop_next   = OP_P1;
                paddr_next = rd_addr;
                pt_next    = t_reg;
                if (t_end)
                begin
                    state_next = ST_GAP1;
                end
                else
                begin
                    t_next = t_reg + 6'd1;
                end
            end
            ST_SCAN2:
            begin
                rd_en      = 1'b1;
                pv_next    = 1'b1;
                pop_next   = OP_P2;
                paddr_next = rd_addr;
                pt_next    = t_reg;
                if (t_reg == lim_reg - 6'd1)
                begin
                    state_next = ST_GAP2;
                end
                else
                begin
                    t_next = t_reg + 6'd1;
                end
            end
            ST_GAP1, ST_GAP2:
            begin
                if ((state_reg == ST_GAP1) && (have_lim_reg || close_evt))
                begin
                    // Second walk of this line decrements the inner runs
                    t_next     = '0;
                    par_next   = 1'b0;
                    state_next = ST_SCAN2;
                end
                else
                begin
                    t_next        = '0;
                    par_next      = 1'b0;
                    have_lim_next = 1'b0;
                    state_next    = ST_SCAN1;
                    if (!v_end)
                    begin
                        v_next = v_reg + 6'd1;
                    end
                    else
                    begin
                        v_next = '0;
                        if (!u_end)
                        begin
                            u_next = u_reg + 6'd1;
                        end
                        else
                        begin
                            u_next = '0;
                            if (axis_reg == 2'd2)
                            begin
                                state_next = ST_FINAL;
                            end
                            else
                            begin
                                axis_next = axis_reg + 2'd1;
                            end
                        end
                    end
                end
            end
            ST_FINAL:
            begin
                rd_en      = 1'b1;
                pv_next    = 1'b1;
                pop_next   = OP_FIN;
                paddr_next = rd_addr;
                pt_next    = t_reg;
                if (!t_end)
                begin
                    t_next = t_reg + 6'd1;
                end
                else
                begin
                    t_next = '0;
                    if (!v_end)
                    begin
                        v_next = v_reg + 6'd1;
                    end
                    else
                    begin
                        v_next = '0;
                        if (!u_end)
                        begin
                            u_next = u_reg + 6'd1;
                        end
                        else
                        begin
                            state_next = ST_LAST;
                        end
                    end
                end
            end
            ST_QUERY:
            begin
                rd_addr    = cell_addr(px[CRD_W-1:0], py[CRD_W-1:0], pz[CRD_W-1:0]);
                rd_en      = q_in;
                pv_next    = q_in;
                pop_next   = OP_QRY;
                paddr_next = rd_addr;
                if (q_last)
                begin
                    state_next = ST_LAST;
                end
                else if (qc_reg != rm1)
                begin
                    qc_next = qc_reg + 5'sd1;
                end
                else
                begin
                    qc_next = neg_r;
                    if (qb_reg != rm1)
                    begin
                        qb_next = qb_reg + 5'sd1;
                    end
                    else
                    begin
                        qb_next = neg_r;
                        qa_next = qa_reg + 5'sd1;
                    end
                end
            end
            ST_LAST:
            begin
                // Let the last read complete its write or count
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                done_next       = 1'b1;
                done_kind_next  = kind_reg;
                ball_count_next = (kind_reg == KIND_QUERY) ? cnt_reg : '0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg    <= '0;
            report_reg   <= 1'b0;
            pv_reg       <= 1'b0;
            done_reg     <= 1'b0;
            par_reg      <= 1'b0;
            have_lim_reg <= 1'b0;
            axis_reg     <= 2'd0;
            kind_reg     <= KIND_CLEAR;
        end
        else
        begin
            sweep_reg    <= sweep_next;
            report_reg   <= report_next;
            pv_reg       <= pv_next;
            done_reg     <= done_next;
            par_reg      <= par_next;
            have_lim_reg <= have_lim_next;
            axis_reg     <= axis_next;
            kind_reg     <= kind_next;
        end
    end

    // Payload and counters
    always_ff @(posedge clk)
    begin
        xq_reg         <= xq_next;
        yq_reg         <= yq_next;
        zq_reg         <= zq_next;
        t_reg          <= t_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        lim_reg        <= lim_next;
        qa_reg         <= qa_next;
        qb_reg         <= qb_next;
        qc_reg         <= qc_next;
        cnt_reg        <= cnt_next;
        pop_reg        <= pop_next;
        paddr_reg      <= paddr_next;
        pt_reg         <= pt_next;
        done_kind_reg  <= done_kind_next;
        ball_count_reg <= ball_count_next;
    end

    // Voxel memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Configuration registers, writable at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RST;
            size_y_reg <= SIZE_RST;
            size_z_reg <= SIZE_RST;
            radius_reg <= RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default:    radius_reg <= cfg_data[RAD_W-1:0];
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign done_kind  = done_kind_reg;
    assign ball_count = ball_count_reg;

    // A result follows only the report step
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_REPORT))
        else $error("result without report step");

    // Read and write never meet at the same cell in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("read and write to the same cell");

    // Only a query reports a count
    a_count_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (done_kind != KIND_QUERY)) |-> (ball_count == '0))
        else $error("count on a non-query result");

    // No request is taken while a read is still in flight
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !pv_reg)
        else $error("request taken with read in flight");

endmodule
